[rtl/core/apl_pkg.sv]
// Shared types, constants and the microcode program of the audio peak limiter.
// Used by apl_seq and audio_peak_limiter_core; depends on nothing else.
package apl_pkg;

    // Field and register widths.
    localparam int SAMPLE_W  = 24;
    localparam int CEIL_W    = 23;
    localparam int COEFF_W   = 24;
    localparam int ENV_W     = 35;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int PC_W      = 4;
    localparam int CNT_W     = 5;

    // Arithmetic constants.
    localparam logic [ENV_W-1:0] ENV_MAX  = {ENV_W{1'b1}};
    localparam logic [23:0]      ONE_Q22  = 24'd4194304;
    localparam int               QUOT_W   = 25;
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUOT_W - 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [CEIL_W-1:0]  CEILING_RST = 23'd629146;
    localparam logic [COEFF_W-1:0] ATTACK_RST  = 24'd4194304;
    localparam logic [COEFF_W-1:0] RELEASE_RST = 24'd1678;

    // Datapath operations selected by the control word.
    typedef logic [3:0] op_t;
    localparam op_t OP_NOP      = 4'd0;
    localparam op_t OP_LOAD     = 4'd1;
    localparam op_t OP_DIFF     = 4'd2;
    localparam op_t OP_MUL_LO   = 4'd3;
    localparam op_t OP_MUL_HI   = 4'd4;
    localparam op_t OP_ACC      = 4'd5;
    localparam op_t OP_ENV_UPD  = 4'd6;
    localparam op_t OP_GAIN_MUL = 4'd7;
    localparam op_t OP_DIV_INIT = 4'd8;
    localparam op_t OP_DIV_STEP = 4'd9;
    localparam op_t OP_Q_DIV    = 4'd10;
    localparam op_t OP_Q_PASS   = 4'd11;
    localparam op_t OP_EMIT     = 4'd12;

    // Hold conditions: the step waits until its handshake side is ready.
    typedef logic [1:0] hold_t;
    localparam hold_t HOLD_NONE = 2'd0;
    localparam hold_t HOLD_IN   = 2'd1;
    localparam hold_t HOLD_OUT  = 2'd2;

    // Jump conditions.
    typedef logic [1:0] cond_t;
    localparam cond_t COND_NEXT   = 2'd0;
    localparam cond_t COND_ALWAYS = 2'd1;
    localparam cond_t COND_NOT_GT = 2'd2;
    localparam cond_t COND_CNT_NZ = 2'd3;

    // Program addresses.
    localparam logic [PC_W-1:0] PC_FETCH    = 4'd0;
    localparam logic [PC_W-1:0] PC_DIFF     = 4'd1;
    localparam logic [PC_W-1:0] PC_MUL_LO   = 4'd2;
    localparam logic [PC_W-1:0] PC_MUL_HI   = 4'd3;
    localparam logic [PC_W-1:0] PC_ACC      = 4'd4;
    localparam logic [PC_W-1:0] PC_ENV_UPD  = 4'd5;
    localparam logic [PC_W-1:0] PC_GAIN_MUL = 4'd6;
    localparam logic [PC_W-1:0] PC_BRANCH   = 4'd7;
    localparam logic [PC_W-1:0] PC_DIV_INIT = 4'd8;
    localparam logic [PC_W-1:0] PC_DIV_STEP = 4'd9;
    localparam logic [PC_W-1:0] PC_Q_DIV    = 4'd10;
    localparam logic [PC_W-1:0] PC_Q_PASS   = 4'd11;
    localparam logic [PC_W-1:0] PC_EMIT     = 4'd12;

    typedef struct packed {
        op_t              op;
        hold_t            hold;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ctrl_t;

    // Status flags fed back from the datapath and the ports to the sequencer.
    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic gt;
        logic cnt_nz;
    } seq_flags_t;

    // The control store: one word per program step.
    function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = '{op: OP_NOP, hold: HOLD_NONE, cond: COND_ALWAYS, target: PC_FETCH};
        case (pc)
            PC_FETCH:    w = '{OP_LOAD,     HOLD_IN,   COND_NEXT,   PC_FETCH};
            PC_DIFF:     w = '{OP_DIFF,     HOLD_NONE, COND_NEXT,   PC_FETCH};
            PC_MUL_LO:   w = '{OP_MUL_LO,   HOLD_NONE, COND_NEXT,   PC_FETCH};
            PC_MUL_HI:   w = '{OP_MUL_HI,   HOLD_NONE, COND_NEXT,   PC_FETCH};
            PC_ACC:      w = '{OP_ACC,      HOLD_NONE, COND_NEXT,   PC_FETCH};
            PC_ENV_UPD:  w = '{OP_ENV_UPD,  HOLD_NONE, COND_NEXT,   PC_FETCH};
            PC_GAIN_MUL: w = '{OP_GAIN_MUL, HOLD_NONE, COND_NEXT,   PC_FETCH};
            PC_BRANCH:   w = '{OP_NOP,      HOLD_NONE, COND_NOT_GT, PC_Q_PASS};
            PC_DIV_INIT: w = '{OP_DIV_INIT, HOLD_NONE, COND_NEXT,   PC_FETCH};
            PC_DIV_STEP: w = '{OP_DIV_STEP, HOLD_NONE, COND_CNT_NZ, PC_DIV_STEP};
            PC_Q_DIV:    w = '{OP_Q_DIV,    HOLD_NONE, COND_ALWAYS, PC_EMIT};
            PC_Q_PASS:   w = '{OP_Q_PASS,   HOLD_NONE, COND_NEXT,   PC_FETCH};
            PC_EMIT:     w = '{OP_EMIT,     HOLD_OUT,  COND_ALWAYS, PC_FETCH};
            default:     w = '{OP_NOP,      HOLD_NONE, COND_ALWAYS, PC_FETCH};
        endcase
        return w;
    endfunction

endpackage

[rtl/core/audio_peak_limiter_core.sv]
// Audio peak limiter: envelope follower, gain division by the envelope, hard clamp.
// Without gain reduction the divider is skipped; when the envelope is above the ceiling
// the gain passes through a 25-step restoring divider. A new sample is taken only after
// the previous result has been emitted; a finished result waits in the output register
// while the next sample is taken. Reset clears the envelope to zero and loads the
// ceiling and coefficient registers with their defaults.
module audio_peak_limiter_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [apl_pkg::SAMPLE_W-1:0]  sample_in,
    input  logic                                 block_end_in,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [apl_pkg::SAMPLE_W-1:0]  sample_out,
    output logic                                 was_clamped,
    output logic                                 block_end_out,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [apl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [apl_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import apl_pkg::*;

    ctrl_t      ctrl;
    seq_flags_t flags;
    logic       exec;

    // Configuration registers.
    logic [CEIL_W-1:0]  ceiling_reg;
    logic [COEFF_W-1:0] attack_reg;
    logic [COEFF_W-1:0] release_reg;

    // Datapath registers.
    logic [ENV_W-1:0]   env_reg;
    logic [23:0]        mag_reg;
    logic               neg_reg;
    logic               blk_reg;
    logic               up_reg;
    logic [35:0]        d_reg;
    logic [47:0]        prod_reg;
    logic [59:0]        acc_reg;
    logic               gt_reg;
    logic [ENV_W-1:0]   rem_reg;
    logic [QUOT_W-1:0]  quot_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [25:0]        q_reg;
    logic               out_valid_reg;
    logic [SAMPLE_W-1:0] sample_out_reg;
    logic               clamped_reg;
    logic               blk_out_reg;

    // Combinational values.
    logic [23:0]        raw;
    logic [23:0]        mag_next;
    logic [35:0]        a_val;
    logic               up_next;
    logic [35:0]        d_next;
    logic [23:0]        mul_a;
    logic [23:0]        mul_b;
    logic [47:0]        product;
    logic [35:0]        step;
    logic [36:0]        env_sum;
    logic [35:0]        env_diff;
    logic [ENV_W-1:0]   env_next;
    logic [35:0]        rem_shift;
    logic [35:0]        rem_sub;
    logic               rem_ge;
    logic               clamp_hit;
    logic [23:0]        q_mag;
    logic [23:0]        sample_next;
    logic               in_fire;
    logic               emit_fire;

    apl_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .flags    (flags),
        .ctrl     (ctrl),
        .exec     (exec),
        .in_ready (in_ready)
    );

    assign flags.in_valid = in_valid;
    assign flags.out_free = !out_valid_reg || out_ready;
    assign flags.gt       = gt_reg;
    assign flags.cnt_nz   = (cnt_reg != '0);

    assign in_fire   = in_valid && in_ready;
    assign emit_fire = exec && (ctrl.op == OP_EMIT);
    assign cfg_ready = 1'b1;

    // Magnitude of the incoming sample; the most negative code maps to 2^23.
    assign raw      = $unsigned(sample_in);
    assign mag_next = raw[23] ? (24'd0 - raw) : raw;

    // Envelope direction and distance to the magnitude in Q2.34.
    assign a_val    = {mag_reg, 12'd0};
    assign up_next  = a_val > {1'b0, env_reg};
    assign d_next   = up_next ? (a_val - {1'b0, env_reg}) : ({1'b0, env_reg} - a_val);

    // Shared 24x24 multiplier; operands chosen by the current step.
    always_comb
    begin
        case (ctrl.op)
            OP_MUL_LO:
            begin
                mul_a = {6'd0, d_reg[17:0]};
                mul_b = up_reg ? attack_reg : release_reg;
            end
            OP_MUL_HI:
            begin
                mul_a = {6'd0, d_reg[35:18]};
                mul_b = up_reg ? attack_reg : release_reg;
            end
            OP_GAIN_MUL:
            begin
                mul_a = mag_reg;
                mul_b = {1'b0, ceiling_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;

    // Envelope update with saturation on the way up.
    assign step     = acc_reg[59:24];
    assign env_sum  = {2'd0, env_reg} + {1'b0, step};
    assign env_diff = {1'b0, env_reg} - step;

    always_comb
    begin
        if (up_reg)
        begin
            env_next = (env_sum > {2'd0, ENV_MAX}) ? ENV_MAX : env_sum[ENV_W-1:0];
        end
        else
        begin
            env_next = env_diff[ENV_W-1:0];
        end
    end

    // One restoring division step: shift in the next numerator bit, try to subtract.
    assign rem_shift = {rem_reg, quot_reg[QUOT_W-1]};
    assign rem_sub   = rem_shift - {1'b0, env_reg};
    assign rem_ge    = rem_shift >= {1'b0, env_reg};

    // Hard clamp to plus or minus one and sign restore.
    assign clamp_hit   = q_reg > {2'd0, ONE_Q22};
    assign q_mag       = clamp_hit ? ONE_Q22 : q_reg[23:0];
    assign sample_next = neg_reg ? (24'd0 - q_mag) : q_mag;

    // Control state: configuration, envelope, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceiling_reg   <= CEILING_RST;
            attack_reg    <= ATTACK_RST;
            release_reg   <= RELEASE_RST;
            env_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CEILING: ceiling_reg <= cfg_data[CEIL_W-1:0];
                    CFG_ATTACK:  attack_reg  <= cfg_data[COEFF_W-1:0];
                    CFG_RELEASE: release_reg <= cfg_data[COEFF_W-1:0];
                    default:     ;
                endcase
            end
            if (exec && (ctrl.op == OP_ENV_UPD))
            begin
                env_reg <= env_next;
            end
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath payload registers driven by the control word.
    always_ff @(posedge clk)
    begin
        if (exec)
        begin
            case (ctrl.op)
                OP_LOAD:
                begin
                    mag_reg <= mag_next;
                    neg_reg <= raw[23];
                    blk_reg <= block_end_in;
                end
                OP_DIFF:
                begin
                    up_reg <= up_next;
                    d_reg  <= d_next;
                end
                OP_MUL_LO:
                begin
                    prod_reg <= product;
                end
                OP_MUL_HI:
                begin
                    acc_reg  <= {12'd0, prod_reg};
                    prod_reg <= product;
                end
                OP_ACC:
                begin
                    acc_reg <= acc_reg + {prod_reg[41:0], 18'd0};
                end
                OP_GAIN_MUL:
                begin
                    prod_reg <= product;
                    gt_reg   <= env_reg > {ceiling_reg, 12'd0};
                end
                OP_DIV_INIT:
                begin
                    rem_reg  <= prod_reg[45:11];
                    quot_reg <= {prod_reg[10:0], 14'd0};
                    cnt_reg  <= DIV_LAST;
                end
                OP_DIV_STEP:
                begin
                    rem_reg  <= rem_ge ? rem_sub[ENV_W-1:0] : rem_shift[ENV_W-1:0];
                    quot_reg <= {quot_reg[QUOT_W-2:0], rem_ge};
                    cnt_reg  <= cnt_reg - 1'b1;
                end
                OP_Q_DIV:
                begin
                    q_reg <= {1'b0, quot_reg};
                end
                OP_Q_PASS:
                begin
                    q_reg <= {mag_reg, 2'd0};
                end
                OP_EMIT:
                begin
                    sample_out_reg <= sample_next;
                    clamped_reg    <= clamp_hit;
                    blk_out_reg    <= blk_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign sample_out    = $signed(sample_out_reg);
    assign was_clamped   = clamped_reg;
    assign block_end_out = blk_out_reg;

    // A new sample is never taken in the cycle right after one was taken.
    a_no_double_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("input taken twice in a row");

    // Emitting a result always leaves it valid on the output.
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> out_valid)
        else $error("emitted result not valid");

    // The divider exits to the quotient step after its last iteration.
    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && (ctrl.op == OP_DIV_STEP) && (cnt_reg == '0)) |=> (ctrl.op == OP_Q_DIV))
        else $error("divider loop did not terminate");

    // Results stay within plus or minus one in Q.22.
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((sample_out <= 24'sd4194304) && (sample_out >= -24'sd4194304)))
        else $error("output sample beyond full scale");

    // The clamp flag always goes with a full-scale sample.
    a_clamp_level: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && was_clamped) |->
            ((sample_out == 24'sd4194304) || (sample_out == -24'sd4194304)))
        else $error("clamp flag without full-scale sample");

endmodule

[rtl/core/apl_seq.sv]
// Microcode sequencer of the peak limiter: step counter, control store and jumps.
// Depends on apl_pkg for the control word layout and the program.
module apl_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  apl_pkg::seq_flags_t flags,
    output apl_pkg::ctrl_t      ctrl,
    output logic                exec,
    output logic                in_ready
);
    import apl_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            taken;

    // Fetch the control word of the current step.
    assign ctrl = ucode_rom(pc_reg);

    // A step runs once its hold condition is met.
    always_comb
    begin
        case (ctrl.hold)
            HOLD_IN:  exec = flags.in_valid;
            HOLD_OUT: exec = flags.out_free;
            default:  exec = 1'b1;
        endcase
    end

    assign in_ready = (ctrl.hold == HOLD_IN);

    // Jump condition evaluation.
    always_comb
    begin
        case (ctrl.cond)
            COND_ALWAYS: taken = 1'b1;
            COND_NOT_GT: taken = !flags.gt;
            COND_CNT_NZ: taken = flags.cnt_nz;
            default:     taken = 1'b0;
        endcase
    end

    // Next step address: hold, jump or fall through.
    always_comb
    begin
        if (!exec)
        begin
            pc_next = pc_reg;
        end
        else if (taken)
        begin
            pc_next = ctrl.target;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule
